/* rtl/mahs_pkg.sv */
// Shared types, constants and header-decode functions for the MPEG audio
// header scanner. No dependencies.

package mahs_pkg;

    localparam int SKIP_OFFSET   = 2048;
    localparam int JOB_DEPTH     = 2;
    localparam int SIZE_W        = 40;
    localparam int DIVIDEND_W    = SIZE_W + 3;
    localparam int DIV_STEPS     = DIVIDEND_W;
    localparam int RATE_W        = 9;
    localparam int FREQ_W        = 16;
    localparam int LEN_W         = 32;
    localparam int CODES_W       = 10;

    localparam logic [7:0] SYNC_BYTE   = 8'hFF;
    localparam logic [7:0] SYNC2_MASK  = 8'hE0;
    localparam logic [7:0] VER_MASK    = 8'h18;
    localparam logic [7:0] LAYER_MASK  = 8'h06;
    localparam logic [7:0] BIDX_MASK   = 8'hF0;
    localparam logic [7:0] RIDX_MASK   = 8'h0C;

    localparam logic [1:0] VER_25       = 2'd0;
    localparam logic [1:0] VER_RESERVED = 2'd1;
    localparam logic [1:0] VER_2        = 2'd2;
    localparam logic [1:0] VER_1        = 2'd3;
    localparam logic [1:0] LAYER_RESERVED = 2'd0;
    localparam logic [1:0] LAYER_II       = 2'd2;
    localparam logic [1:0] LAYER_I        = 2'd3;

    localparam logic [0:0] REG_FILE_SIZE    = 1'd0;
    localparam logic [0:0] REG_LENGTH_KNOWN = 1'd1;

    // rows: V1 L1, V1 L2, V1 L3, V2/V2.5 L1, V2/V2.5 L2 and L3
    localparam logic [RATE_W-1:0] RATE_TABLE [0:4][0:15] = '{
        '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
          9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0},
        '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
          9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
        '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
          9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0},
        '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
          9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
        '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
          9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0}
    };

    localparam logic [FREQ_W-1:0] BASE_FREQ [0:3] = '{
        16'd44100, 16'd48000, 16'd32000, 16'd0
    };

    typedef struct packed {
        logic               found;
        logic [CODES_W-1:0] codes;
    } job_t;

    typedef struct packed {
        logic [SIZE_W-1:0] size_bytes;
        logic              length_known;
    } cfg_t;

    typedef struct packed {
        logic               valid;
        logic [CODES_W-1:0] codes;
    } hdr_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIVIDE,
        BK_DELIVER
    } back_state_t;

    function automatic logic [RATE_W-1:0] lookup_bitrate(input logic [CODES_W-1:0] codes);
        logic [1:0] ver;
        logic [1:0] lay;
        logic [2:0] row;
        ver = codes[9:8];
        lay = codes[7:6];
        if (ver == VER_1)
            row = (lay == LAYER_I) ? 3'd0 : (lay == LAYER_II) ? 3'd1 : 3'd2;
        else
            row = (lay == LAYER_I) ? 3'd3 : 3'd4;
        return RATE_TABLE[row][codes[5:2]];
    endfunction

    function automatic logic [FREQ_W-1:0] lookup_freq(input logic [CODES_W-1:0] codes);
        logic [FREQ_W-1:0] f;
        f = BASE_FREQ[codes[1:0]];
        if (codes[9:8] == VER_2)
            return f >> 1;
        if (codes[9:8] == VER_25)
            return f >> 2;
        return f;
    endfunction

    function automatic hdr_t check_header(input logic [7:0] b0, input logic [7:0] b1,
                                          input logic [7:0] b2);
        hdr_t       h;
        logic [1:0] ver;
        logic [1:0] lay;
        ver = b1[4:3];
        lay = b1[2:1];
        h.codes = {ver, lay, b2[7:4], b2[3:2]};
        h.valid = (b0 == SYNC_BYTE) && ((b1 & SYNC2_MASK) == SYNC2_MASK)
                  && (ver != VER_RESERVED) && (lay != LAYER_RESERVED)
                  && (lookup_bitrate(h.codes) != '0) && (lookup_freq(h.codes) != '0);
        return h;
    endfunction

endpackage

/* rtl/mpeg_audio_header_scanner.sv */
// Top level of the MPEG audio header scanner: configuration registers,
// scanner, job queue and result unit. Depends on mahs_pkg and mahs_* modules.

// Bytes are taken one per cycle whenever full is low; the scanner is a single
// stage. The byte marked last hands a job word to a two-entry queue. With the
// result register free, the result unit picks up the job, runs the 43-step
// bit-serial divide of the file size times 8 by the bitrate when a length is
// computed, and then loads the result word.
// The scanner keeps accepting bytes of the next buffers while fewer than two
// jobs wait; full rises only when both queue entries are taken. A result
// word is held on the output ports until popped.
module mpeg_audio_header_scanner #(
    parameter int MAX_BUFFER_BYTES = 8192
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [0:0]                    cfg_index,
    input  logic [mahs_pkg::SIZE_W-1:0]   cfg_data,
    input  logic                          push,
    output logic                          full,
    input  logic [7:0]                    data_byte,
    input  logic                          last_byte,
    input  logic                          pop,
    output logic                          empty,
    output logic                          header_found,
    output logic [mahs_pkg::RATE_W-1:0]   bitrate_kbps,
    output logic [mahs_pkg::FREQ_W-1:0]   sample_rate_hz,
    output logic [mahs_pkg::LEN_W-1:0]    length_ms,
    output logic                          length_valid
);
    import mahs_pkg::*;

    cfg_t cfg_reg;
    logic accept;
    logic job_push, job_pop, job_avail;
    job_t job_in, job_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_FILE_SIZE:    cfg_reg.size_bytes   <= cfg_data;
                REG_LENGTH_KNOWN: cfg_reg.length_known <= cfg_data[0];
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    assign accept = push && !full;

    mahs_front #(
        .MAX_BUFFER_BYTES(MAX_BUFFER_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .job_push  (job_push),
        .job       (job_in)
    );

    mahs_job_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (job_push),
        .wr_job (job_in),
        .full   (full),
        .pop    (job_pop),
        .avail  (job_avail),
        .rd_job (job_out)
    );

    mahs_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .job_avail      (job_avail),
        .job            (job_out),
        .job_pop        (job_pop),
        .pop            (pop),
        .empty          (empty),
        .header_found   (header_found),
        .bitrate_kbps   (bitrate_kbps),
        .sample_rate_hz (sample_rate_hz),
        .length_ms      (length_ms),
        .length_valid   (length_valid)
    );

endmodule

/* rtl/mahs_front.sv */
// Byte scanner: tracks the last two bytes, finds the first early and late
// frame header and emits one job word per buffer. Depends on mahs_pkg.

module mahs_front #(
    parameter int MAX_BUFFER_BYTES = 8192
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [7:0]    data_byte,
    input  logic          last_byte,
    output logic          job_push,
    output mahs_pkg::job_t job
);
    import mahs_pkg::*;

    localparam int IDX_W = $clog2(MAX_BUFFER_BYTES + 1);
    localparam logic [IDX_W-1:0] IDX_MAX  = IDX_W'(MAX_BUFFER_BYTES);
    localparam logic [IDX_W-1:0] IDX_SKIP = IDX_W'(SKIP_OFFSET);
    localparam logic [IDX_W-1:0] IDX_LATE = IDX_W'(SKIP_OFFSET + 2);

    logic [15:0]        window_reg, window_next;
    logic [IDX_W-1:0]   index_reg, index_next;
    logic               skip_reg, skip_next;
    logic               early_valid_reg, early_valid_next;
    logic [CODES_W-1:0] early_codes_reg, early_codes_next;
    logic               late_valid_reg, late_valid_next;
    logic [CODES_W-1:0] late_codes_reg, late_codes_next;
    logic               in_range;
    hdr_t               hdr;

    always_comb
    begin
        in_range         = index_reg < IDX_MAX;
        hdr              = check_header(window_reg[15:8], window_reg[7:0], data_byte);
        window_next      = window_reg;
        index_next       = index_reg;
        skip_next        = skip_reg;
        early_valid_next = early_valid_reg;
        early_codes_next = early_codes_reg;
        late_valid_next  = late_valid_reg;
        late_codes_next  = late_codes_reg;
        job_push         = 1'b0;
        job              = '0;
        if (accept && in_range)
        begin
            if (index_reg == IDX_SKIP && data_byte == SYNC_BYTE)
                skip_next = 1'b1;
            if (index_reg >= IDX_W'(2) && hdr.valid)
            begin
                if (index_reg < IDX_LATE)
                begin
                    if (!early_valid_reg)
                    begin
                        early_valid_next = 1'b1;
                        early_codes_next = hdr.codes;
                    end
                end
                else if (!late_valid_reg)
                begin
                    late_valid_next = 1'b1;
                    late_codes_next = hdr.codes;
                end
            end
            window_next = {window_reg[7:0], data_byte};
            index_next  = index_reg + IDX_W'(1);
        end
        if (accept && last_byte)
        begin
            job_push = 1'b1;
            priority if (!skip_next && early_valid_next)
                job = '{found: 1'b1, codes: early_codes_next};
            else if (late_valid_next)
                job = '{found: 1'b1, codes: late_codes_next};
            else
                job = '0;
            // restart the scan for the next buffer
            window_next      = '0;
            index_next       = '0;
            skip_next        = 1'b0;
            early_valid_next = 1'b0;
            early_codes_next = '0;
            late_valid_next  = 1'b0;
            late_codes_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg      <= '0;
            index_reg       <= '0;
            skip_reg        <= 1'b0;
            early_valid_reg <= 1'b0;
            early_codes_reg <= '0;
            late_valid_reg  <= 1'b0;
            late_codes_reg  <= '0;
        end
        else
        begin
            window_reg      <= window_next;
            index_reg       <= index_next;
            skip_reg        <= skip_next;
            early_valid_reg <= early_valid_next;
            early_codes_reg <= early_codes_next;
            late_valid_reg  <= late_valid_next;
            late_codes_reg  <= late_codes_next;
        end
    end

    a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        index_reg <= IDX_MAX)
        else $error("byte index ran past buffer limit");

    a_skip_needs_index: assert property (@(posedge clk) disable iff (!rst_n)
        skip_reg |-> index_reg > IDX_SKIP)
        else $error("skip mode set before offset 2048 was seen");

    a_late_needs_index: assert property (@(posedge clk) disable iff (!rst_n)
        late_valid_reg |-> index_reg >= IDX_LATE)
        else $error("late hit recorded too early");

endmodule

/* rtl/mahs_job_fifo.sv */
// Short job queue between the scanner and the length unit.
// Depends on mahs_pkg.

module mahs_job_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  mahs_pkg::job_t wr_job,
    output logic           full,
    input  logic           pop,
    output logic           avail,
    output mahs_pkg::job_t rd_job
);
    import mahs_pkg::*;

    localparam int PTR_W = $clog2(JOB_DEPTH);
    localparam int CNT_W = $clog2(JOB_DEPTH + 1);

    job_t             mem [JOB_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full    = count_reg == CNT_W'(JOB_DEPTH);
    assign avail   = count_reg != '0;
    assign do_push = push && !full;
    assign do_pop  = pop && avail;
    assign rd_job  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= wr_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(JOB_DEPTH - 1)) ? '0
                              : wr_ptr_reg + PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(JOB_DEPTH - 1)) ? '0
                              : rd_ptr_reg + PTR_W'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(JOB_DEPTH))
        else $error("job queue count out of range");

    a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
        do_pop && !do_push |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("job queue count did not drop on pop");

    a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
        do_push && !do_pop |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("job queue count did not rise on push");

endmodule

/* rtl/mahs_back.sv */
// Result unit: looks up bitrate and sample rate for a job word, runs the
// bit-serial length divide and holds the result word. Depends on mahs_pkg.

module mahs_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mahs_pkg::cfg_t                cfg,
    input  logic                          job_avail,
    input  mahs_pkg::job_t                job,
    output logic                          job_pop,
    input  logic                          pop,
    output logic                          empty,
    output logic                          header_found,
    output logic [mahs_pkg::RATE_W-1:0]   bitrate_kbps,
    output logic [mahs_pkg::FREQ_W-1:0]   sample_rate_hz,
    output logic [mahs_pkg::LEN_W-1:0]    length_ms,
    output logic                          length_valid
);
    import mahs_pkg::*;

    localparam int STEP_W = $clog2(DIV_STEPS + 1);

    back_state_t           state_reg, state_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [DIVIDEND_W-1:0] quot_reg, quot_next;
    logic [RATE_W-1:0]     rem_reg, rem_next;
    logic                  found_reg, found_next;
    logic [RATE_W-1:0]     rate_reg, rate_next;
    logic [FREQ_W-1:0]     freq_reg, freq_next;
    logic                  len_ok_reg, len_ok_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_found_reg, out_found_next;
    logic [RATE_W-1:0]     out_rate_reg, out_rate_next;
    logic [FREQ_W-1:0]     out_freq_reg, out_freq_next;
    logic [LEN_W-1:0]      out_len_reg, out_len_next;
    logic                  out_len_ok_reg, out_len_ok_next;
    logic [RATE_W:0]       trial;
    logic                  trial_ge;
    logic [RATE_W-1:0]     job_rate;
    logic [FREQ_W-1:0]     job_freq;
    logic                  job_len_ok;

    always_comb
    begin
        job_rate   = job.found ? lookup_bitrate(job.codes) : '0;
        job_freq   = job.found ? lookup_freq(job.codes) : '0;
        job_len_ok = job.found && !cfg.length_known && (cfg.size_bytes != '0)
                     && (job_rate != '0);
        trial      = {rem_reg, quot_reg[DIVIDEND_W-1]};
        trial_ge   = trial >= {1'b0, rate_reg};

        state_next      = state_reg;
        step_next       = step_reg;
        quot_next       = quot_reg;
        rem_next        = rem_reg;
        found_next      = found_reg;
        rate_next       = rate_reg;
        freq_next       = freq_reg;
        len_ok_next     = len_ok_reg;
        out_valid_next  = out_valid_reg && !pop;
        out_found_next  = out_found_reg;
        out_rate_next   = out_rate_reg;
        out_freq_next   = out_freq_reg;
        out_len_next    = out_len_reg;
        out_len_ok_next = out_len_ok_reg;
        job_pop         = 1'b0;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (job_avail)
                begin
                    job_pop     = 1'b1;
                    found_next  = job.found;
                    rate_next   = job_rate;
                    freq_next   = job_freq;
                    len_ok_next = job_len_ok;
                    quot_next   = {cfg.size_bytes, 3'b000};
                    rem_next    = '0;
                    step_next   = STEP_W'(DIV_STEPS);
                    state_next  = job_len_ok ? BK_DIVIDE : BK_DELIVER;
                end
            end
            BK_DIVIDE:
            begin
                // one quotient bit per cycle, restoring form
                rem_next  = trial_ge ? RATE_W'(trial - {1'b0, rate_reg})
                                     : trial[RATE_W-1:0];
                quot_next = {quot_reg[DIVIDEND_W-2:0], trial_ge};
                step_next = step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1))
                    state_next = BK_DELIVER;
            end
            BK_DELIVER:
            begin
                // hold until the result register is free
                if (!out_valid_reg || pop)
                begin
                    out_valid_next  = 1'b1;
                    out_found_next  = found_reg;
                    out_rate_next   = rate_reg;
                    out_freq_next   = freq_reg;
                    out_len_ok_next = len_ok_reg;
                    out_len_next    = len_ok_reg ? quot_reg[LEN_W-1:0] : '0;
                    state_next      = BK_IDLE;
                end
            end
            default:
                state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg       <= quot_next;
        rem_reg        <= rem_next;
        found_reg      <= found_next;
        rate_reg       <= rate_next;
        freq_reg       <= freq_next;
        len_ok_reg     <= len_ok_next;
        out_found_reg  <= out_found_next;
        out_rate_reg   <= out_rate_next;
        out_freq_reg   <= out_freq_next;
        out_len_reg    <= out_len_next;
        out_len_ok_reg <= out_len_ok_next;
    end

    assign empty          = !out_valid_reg;
    assign header_found   = out_found_reg;
    assign bitrate_kbps   = out_rate_reg;
    assign sample_rate_hz = out_freq_reg;
    assign length_ms      = out_len_reg;
    assign length_valid   = out_len_ok_reg;

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !pop |=> out_valid_reg && $stable(out_len_reg)
                                  && $stable(out_rate_reg))
        else $error("pending result word changed before pop");

    a_len_implies_found: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_len_ok_reg |-> out_found_reg && out_rate_reg != '0)
        else $error("length flagged without a header");

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |-> state_reg == BK_IDLE && job_avail)
        else $error("job taken while busy");

    a_divide_steps: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BK_DIVIDE |-> step_reg != '0)
        else $error("divide ran out of steps");

endmodule
